// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/tira_pkg.sv =====
// ----------------------------------------------------------------------------
// tira_pkg
// Types, codes and helper functions of the typed integer register ALU.
// ----------------------------------------------------------------------------
package tira_pkg;

	localparam int NumRegsDefault = 256;

	localparam logic [4:0] K_LDI = 5'd0, K_MOV = 5'd1, K_AND = 5'd2, K_OR = 5'd3,
		K_XOR = 5'd4, K_NOT = 5'd5, K_INC = 5'd6, K_ABS = 5'd7, K_NEG = 5'd8,
		K_DEC = 5'd9, K_SHL = 5'd10, K_SHR = 5'd11, K_ADD = 5'd12, K_SUB = 5'd13,
		K_MUL = 5'd14, K_DIV = 5'd15, K_LAND = 5'd16, K_LOR = 5'd17,
		K_LXOR = 5'd18, K_LNOT = 5'd19, K_CEQ = 5'd20, K_CGT = 5'd21,
		K_CGE = 5'd22, K_CLT = 5'd23, K_CLE = 5'd24;

	localparam logic [1:0] ST_OK = 2'd0, ST_BADTYPE = 2'd1, ST_DIVZERO = 2'd2;

	localparam logic [3:0] T_S64 = 4'd6, T_U64 = 4'd7;

	typedef struct packed {
		logic [4:0]  kind;
		logic [3:0]  dest_type;
		logic [7:0]  dest_index;
		logic [3:0]  a_type;
		logic [7:0]  a_index;
		logic [3:0]  b_type;
		logic [7:0]  b_index;
		logic signed [63:0] immediate;
	} instr_t;

	typedef struct packed {
		logic signed [63:0] written_value;
		logic        wrote;
		logic        compare_flag;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_RDA, S_RDB, S_WAITB, S_EXEC, S_MUL, S_DIV, S_FIN, S_WB
	} state_t;

	// Request from the sequencer to the shared iterative unit.
	typedef struct packed {
		logic start_mul;
		logic start_div;
	} itu_ctl_t;

	// Width mask of the low part of a typed view.
	function automatic logic [63:0] low_mask(input logic [3:0] t);
		case (t[2:1])
			2'd0:    low_mask = 64'h0000_0000_0000_00ff;
			2'd1:    low_mask = 64'h0000_0000_0000_ffff;
			2'd2:    low_mask = 64'h0000_0000_ffff_ffff;
			default: low_mask = 64'hffff_ffff_ffff_ffff;
		endcase
	endfunction

	// Typed view of a register value.
	function automatic logic [63:0] view(input logic [3:0] t, input logic [63:0] v);
		logic [63:0] m;
		m = low_mask(t);
		if (t == T_S64) view = v;
		else if (t == T_U64) view = {1'b0, v[62:0]};
		else if (t[0]) view = v & m;
		else if (v[63]) view = v | ~m;
		else view = v & m;
	endfunction

	// Load-immediate extension by destination type.
	function automatic logic [63:0] imm_ext(input logic [3:0] t, input logic [63:0] v);
		logic [63:0] m;
		logic [63:0] x;
		m = low_mask(t);
		x = v & m;
		if (t >= T_S64) imm_ext = v;
		else if (t[0]) imm_ext = x;
		else begin
			case (t[2:1])
				2'd0:    imm_ext = {{56{x[7]}}, x[7:0]};
				2'd1:    imm_ext = {{48{x[15]}}, x[15:0]};
				default: imm_ext = {{32{x[31]}}, x[31:0]};
			endcase
		end
	endfunction

endpackage

// ===== rtl/tira_ram.sv =====
// ----------------------------------------------------------------------------
// tira_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module tira_ram #(
	parameter int Width = 64,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// At most one write each cycle; the addressed word is read every cycle, giving its old value on a write.
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/tira_itu.sv =====
// ----------------------------------------------------------------------------
// tira_itu
// Shared iterative unit: shift-add multiply and restoring signed divide,
// one bit each cycle.
// ----------------------------------------------------------------------------
module tira_itu import tira_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  itu_ctl_t    ctl,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] res
);
	logic [63:0] acc_q, x_q, y_q, rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q, mul_q, neg_q;
	logic [64:0] trial;

	assign trial = {rem_q, x_q[63]} - {1'b0, y_q};

	// One bit of product or quotient per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			mul_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start_mul || ctl.start_div) begin
				busy_q <= 1'b1;
				mul_q  <= ctl.start_mul;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start_mul) begin
			acc_q <= '0;
			x_q   <= a;
			y_q   <= b;
		end else if (ctl.start_div) begin
			rem_q <= '0;
			x_q   <= a[63] ? -a : a;
			y_q   <= b[63] ? -b : b;
			neg_q <= a[63] ^ b[63];
		end else if (busy_q) begin
			if (mul_q) begin
				if (y_q[0]) acc_q <= acc_q + x_q;
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end else begin
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					x_q   <= {x_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], x_q[63]};
					x_q   <= {x_q[62:0], 1'b0};
				end
			end
		end
	end

	assign res = mul_q ? acc_q : (neg_q ? -x_q : x_q);
endmodule

// ===== rtl/typed_integer_register_alu.sv =====
// ----------------------------------------------------------------------------
// typed_integer_register_alu
// Executes one decoded integer instruction against a 64-bit register file.
// ----------------------------------------------------------------------------
// Each instruction steps through S_RDA, S_RDB and S_WAITB, then S_EXEC for most ops or the
// one-bit-a-cycle shared multiply/divide unit for mul and div, then S_WB and S_FIN.
// busy stays high while an instruction runs; one instruction at a time,
// bounded by the single register file port (reads of a and b are serial).
// Compares and faults skip from S_WAITB to S_FIN. After reset a clearing pass zeroes the register file.
// Results are shown for one cycle on done; the receiver cannot stall.
module typed_integer_register_alu import tira_pkg::*; #(
	parameter int NUM_REGS = NumRegsDefault
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  instr_t  instr,
	output logic    busy,
	output logic    done,
	output result_t result
);
	localparam int AW = $clog2(NUM_REGS);

	state_t state_q, state_d;
	instr_t ins_q;
	logic [AW:0]   clr_q;
	logic [63:0]   a_q, b_q, r_q;
	logic          flag_q, ok_q, wr_q;
	logic [1:0]    st_q;
	logic          we;
	logic [AW-1:0] addr;
	logic [63:0]   wdata, rdata;
	itu_ctl_t      ctl;
	logic          itu_done;
	logic [63:0]   itu_res;
	logic          need_a, need_b, is_inc, is_cmp, a_in, b_in, d_in;
	logic [3:0]    a_t;
	logic [7:0]    a_i;
	logic [63:0]   a_v, b_v, alu_r;
	logic          bad;

	tira_ram #(.Width(64), .Depth(NUM_REGS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// The b operand is taken straight from the read port as the unit starts.
	tira_itu u_itu (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(a_q), .b(b_v),
		.done(itu_done), .res(itu_res)
	);

	// Operand decode.
	always_comb begin
		need_a = (ins_q.kind >= K_MOV && ins_q.kind <= K_NOT) || ins_q.kind == K_ABS
			|| ins_q.kind == K_NEG || ins_q.kind >= K_SHL;
		need_b = (ins_q.kind >= K_AND && ins_q.kind <= K_XOR) || ins_q.kind >= K_SHL;
		is_inc = ins_q.kind == K_INC || ins_q.kind == K_DEC;
		is_cmp = ins_q.kind >= K_CEQ && ins_q.kind <= K_CLE;
		a_t    = is_inc ? ins_q.dest_type : ins_q.a_type;
		a_i    = is_inc ? ins_q.dest_index : ins_q.a_index;
		a_in   = {24'd0, a_i} < NUM_REGS;
		b_in   = {24'd0, ins_q.b_index} < NUM_REGS;
		d_in   = {24'd0, ins_q.dest_index} < NUM_REGS;
		a_v    = a_in ? view(a_t, rdata) : 64'd0;
		b_v    = b_in ? view(ins_q.b_type, rdata) : 64'd0;
		bad    = ((need_a || is_inc) && a_t[3]) || (need_b && ins_q.b_type[3])
			|| (!is_cmp && ins_q.dest_type[3]);
	end

	// Combinational results of the non-iterative ops on the captured views, or on the immediate for load-immediate.
	always_comb begin
		case (ins_q.kind)
			K_LDI:  alu_r = imm_ext(ins_q.dest_type, ins_q.immediate);
			K_MOV:  alu_r = a_q;
			K_AND:  alu_r = a_q & b_q;
			K_OR:   alu_r = a_q | b_q;
			K_XOR:  alu_r = a_q ^ b_q;
			K_NOT:  alu_r = ~a_q;
			K_INC:  alu_r = a_q + 64'd1;
			K_ABS:  alu_r = a_q[63] ? -a_q : a_q;
			K_NEG:  alu_r = -a_q;
			K_DEC:  alu_r = a_q - 64'd1;
			K_SHL:  alu_r = a_q << b_q[5:0];
			K_SHR:  alu_r = $signed(a_q) >>> b_q[5:0];
			K_ADD:  alu_r = a_q + b_q;
			K_SUB:  alu_r = a_q - b_q;
			K_LAND: alu_r = {63'd0, (a_q != 0) && (b_q != 0)};
			K_LOR:  alu_r = {63'd0, (a_q != 0) || (b_q != 0)};
			K_LXOR: alu_r = {63'd0, (a_q != 0) != (b_q != 0)};
			default: alu_r = {63'd0, a_q == 0};
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:   if (clr_q == (AW+1)'(NUM_REGS - 1)) state_d = S_IDLE;
			S_IDLE:  if (start) state_d = S_RDA;
			S_RDA:   state_d = S_RDB;
			S_RDB:   state_d = S_WAITB;
			S_WAITB: begin
				if (bad || ins_q.kind > K_CLE || is_cmp) state_d = S_FIN;
				else if (ins_q.kind == K_MUL) state_d = S_MUL;
				else if (ins_q.kind == K_DIV) state_d = (b_v == 0) ? S_FIN : S_DIV;
				else state_d = S_EXEC;
			end
			S_EXEC:  state_d = S_WB;
			S_MUL, S_DIV: if (itu_done) state_d = S_WB;
			S_WB:    state_d = S_FIN;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		busy  = state_q != S_IDLE;
		ctl.start_mul = state_q == S_WAITB && state_d == S_MUL;
		ctl.start_div = state_q == S_WAITB && state_d == S_DIV;
		we    = (state_q == S_CLR) || (state_q == S_WB && d_in);
		wdata = (state_q == S_CLR) ? 64'd0 : r_q;
		unique case (state_q)
			S_CLR:   addr = clr_q[AW-1:0];
			S_RDA:   addr = a_i[AW-1:0];
			S_RDB:   addr = ins_q.b_index[AW-1:0];
			default: addr = ins_q.dest_index[AW-1:0];
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			flag_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= state_q == S_FIN;
			if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
			if (state_q == S_WAITB && !bad && is_cmp) begin
				case (ins_q.kind)
					K_CEQ:   flag_q <= a_q == b_v;
					K_CGT:   flag_q <= $signed(b_v) < $signed(a_q);
					K_CGE:   flag_q <= !($signed(a_q) < $signed(b_v));
					K_CLT:   flag_q <= $signed(a_q) < $signed(b_v);
					default: flag_q <= !($signed(b_v) < $signed(a_q));
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			ins_q <= instr;
			wr_q  <= 1'b0;
			st_q  <= ST_OK;
		end
		if (state_q == S_RDB) a_q <= a_v;
		if (state_q == S_WAITB) begin
			b_q <= b_v;
			if (bad && ins_q.kind <= K_CLE) st_q <= ST_BADTYPE;
			else if (ins_q.kind == K_DIV && b_v == 0) st_q <= ST_DIVZERO;
		end
		if (state_q == S_EXEC) r_q <= (ins_q.kind == K_LDI) ? alu_r
			: view(ins_q.dest_type, alu_r);
		if ((state_q == S_MUL || state_q == S_DIV) && itu_done)
			r_q <= view(ins_q.dest_type, itu_res);
		if (state_q == S_WB) wr_q <= d_in;
	end

	assign ok_q = wr_q;
	assign result.written_value = ok_q ? r_q : 64'd0;
	assign result.wrote = wr_q;
	assign result.compare_flag = flag_q;
	assign result.status = st_q;
endmodule

// ===== rtl/tira_checker.sv =====
// ----------------------------------------------------------------------------
// tira_checker
// Port-level checks of the typed integer register ALU.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tira_checker import tira_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);
	`CHK_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "busy not raised after a beat")
	`CHK_IMPLY(a_done_idle, clk, arst_n, done, !busy, "done while busy")
	`CHK_IMPLY(a_nowrite_zero, clk, arst_n, done && !result.wrote, result.written_value == 0, "value without write")
	`CHK_IMPLY(a_write_ok, clk, arst_n, done && result.wrote, result.status == ST_OK, "write with error status")
endmodule

bind typed_integer_register_alu tira_checker u_tira_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);
